// ===== hdl/mpe_pkg.sv =====
// shared types, constants and saturation helper for the polynomial evaluator
// no dependencies; imported by mpe_mulq and multivariate_polynomial_eval
package mpe_pkg;

    localparam int MPE_MAX_TERMS = 128;
    localparam int MPE_NUM_VARS  = 3;
    localparam int MPE_MAX_POWER = 10;

    localparam int QW   = 48;   // internal q32.16 width
    localparam int DW   = 32;   // q16.16 operand width
    localparam int NVAR = 3;    // variables carried by the ports

    localparam logic signed [QW-1:0] ONE_Q16 = 48'sd65536;
    localparam logic signed [QW-1:0] LIM_POS = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [QW-1:0] LIM_NEG = 48'sh8000_0000_0000;

    // configuration register indexes
    localparam logic [3:0] REG_TERM_COUNT = 4'd0;
    localparam logic [3:0] REG_MEAN       = 4'd1;
    localparam logic [3:0] REG_UPPER_A    = 4'd2;
    localparam logic [3:0] REG_UPPER_B    = 4'd3;
    localparam logic [3:0] REG_UPPER_C    = 4'd4;
    localparam logic [3:0] REG_SCALE_A    = 4'd5;
    localparam logic [3:0] REG_SCALE_B    = 4'd6;
    localparam logic [3:0] REG_SCALE_C    = 4'd7;

    // command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    typedef logic signed [QW-1:0] t_q48;

    typedef struct packed {
        logic start;
        t_q48 a;
        t_q48 b;
    } t_mul_req;

    typedef struct packed {
        logic done;
        t_q48 res;
        logic sat;
    } t_mul_rsp;

    typedef struct packed {
        t_q48 val;
        logic sat;
    } t_clip;

    // clamp a 50-bit signed value into the 48-bit range
    function automatic t_clip clip48(input logic signed [49:0] x);
        t_clip c;
        if (x > 50'(LIM_POS)) begin
            c.val = LIM_POS;
            c.sat = 1'b1;
        end else if (x < 50'(LIM_NEG)) begin
            c.val = LIM_NEG;
            c.sat = 1'b1;
        end else begin
            c.val = x[QW-1:0];
            c.sat = 1'b0;
        end
        return c;
    endfunction

endpackage

// ===== hdl/mpe_mulq.sv =====
// iterative q32.16 multiplier: 48x48 magnitude product from four 24x24 partial products
// depends on mpe_pkg for the request/response structs and widths
module mpe_mulq import mpe_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    output t_mul_rsp o_rsp
);

    logic            r_busy;
    logic [1:0]      r_cnt;
    logic            r_fin;
    logic            r_done;
    logic [QW-1:0]   r_ua;
    logic [QW-1:0]   r_ub;
    logic            r_neg;
    logic [2*QW-1:0] r_acc;
    t_q48            r_res;
    logic            r_sat;

    logic [23:0]     pa;
    logic [23:0]     pb;
    logic [47:0]     pp;
    logic [2*QW-1:0] pp_sh;
    logic [79:0]     mag;
    logic [79:0]     lim;
    logic [QW-1:0]   mag_cl;
    logic            ovf;

    assign pa = r_cnt[0] ? r_ua[47:24] : r_ua[23:0];
    assign pb = r_cnt[1] ? r_ub[47:24] : r_ub[23:0];
    assign pp = 48'(pa) * 48'(pb);

    always_comb begin
        case (r_cnt)
            2'd0:    pp_sh = 96'(pp);
            2'd1:    pp_sh = 96'(pp) << 24;
            2'd2:    pp_sh = 96'(pp) << 24;
            2'd3:    pp_sh = 96'(pp) << 48;
            default: pp_sh = '0;
        endcase
    end

    // truncate toward zero on the magnitude, then clip
    assign mag    = r_acc[95:16];
    assign lim    = r_neg ? 80'h8000_0000_0000 : 80'h7FFF_FFFF_FFFF;
    assign ovf    = mag > lim;
    assign mag_cl = ovf ? lim[QW-1:0] : mag[QW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            r_fin  <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 2'd1;
                if (r_cnt == 2'd3) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
            if (r_fin) begin
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_ua  <= i_req.a[QW-1] ? QW'(-i_req.a) : QW'(i_req.a);
            r_ub  <= i_req.b[QW-1] ? QW'(-i_req.b) : QW'(i_req.b);
            r_neg <= i_req.a[QW-1] ^ i_req.b[QW-1];
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= r_acc + pp_sh;
        end
        if (r_fin) begin
            r_res <= r_neg ? t_q48'(-mag_cl) : t_q48'(mag_cl);
            r_sat <= ovf;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_res;
    assign o_rsp.sat  = r_sat;

endmodule

// ===== hdl/multivariate_polynomial_eval.sv =====
// top level of the three-variable polynomial evaluator: control sequencer and term memories
// depends on mpe_pkg and instantiates mpe_mulq
//
// usage
//   config channel: write i_cfg_data to register i_cfg_index while the block is idle;
//     0 term count, 1 mean, 2..4 upper bounds, 5..7 scales; other indexes are dropped
//   input stream: tuser is the command (0 load a term, 1 evaluate). a load writes the
//     coefficient and three power codes into the term memories in its accept cycle and
//     gives no output word. an evaluate maps the three coordinates, builds a table of
//     powers of each mapped value, then walks the stored terms through the memories
//   output stream: one word per evaluate, the 48-bit value in tdata, clip flag in tuser
// sequencing
//   every product of an evaluate runs through the one shared four-pass multiplier:
//   first the products of the power table build, then three per term for n terms
//   one item is in work at a time; s_axis_tready is high only between items
// reset clears the configuration to term count 0, bounds 0, scales 1.0 and drops any
// pending output word. the term memories are not cleared: terms must be loaded before use
// a stalled receiver holds the output word; the next evaluate may run meanwhile and
// waits at its end until the word is taken
module multivariate_polynomial_eval import mpe_pkg::*; #(
    parameter int MAX_TERMS = MPE_MAX_TERMS,
    parameter int NUM_VARS  = MPE_NUM_VARS,
    parameter int MAX_POWER = MPE_MAX_POWER
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // config write channel
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [3:0]    i_cfg_index,
    input  logic [31:0]   i_cfg_data,
    // input stream
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // term_index[6:0] coefficient[38:7] power_a[42:39] power_b[46:43] power_c[50:47]
    // coord_a[82:51] coord_b[114:83] coord_c[146:115], zero pad [151:147]
    input  logic [151:0]  s_axis_tdata,
    input  logic          s_axis_tuser,   // command
    // output stream
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [47:0]   m_axis_tdata,   // poly_value[47:0]
    output logic          m_axis_tuser    // saturated
);

    localparam int AW  = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int CW  = ($clog2(MAX_TERMS + 1) > 8) ? $clog2(MAX_TERMS + 1) : 8;
    localparam int PIW = (MAX_POWER > 1) ? $clog2(MAX_POWER) : 1;
    localparam int KW  = $clog2(MAX_POWER + 1);

    // sequencer states
    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_MAP_MUL   = 4'd1;
    localparam logic [3:0] S_MAP_ADD   = 4'd2;
    localparam logic [3:0] S_POW_START = 4'd3;
    localparam logic [3:0] S_POW_WAIT  = 4'd4;
    localparam logic [3:0] S_T_RD      = 4'd5;
    localparam logic [3:0] S_T_LAT     = 4'd6;
    localparam logic [3:0] S_T_MUL     = 4'd7;
    localparam logic [3:0] S_T_WAIT    = 4'd8;
    localparam logic [3:0] S_T_ACC     = 4'd9;
    localparam logic [3:0] S_FIN       = 4'd10;

    // configuration
    logic [7:0]            r_term_count;
    logic signed [DW-1:0]  r_mean;
    logic signed [DW-1:0]  r_upper [NVAR];
    logic signed [DW-1:0]  r_scale [NVAR];

    // term memories, one write port and one registered read port each
    logic [DW-1:0]         r_coef_mem [MAX_TERMS];
    logic [11:0]           r_pow_mem  [MAX_TERMS];
    logic [DW-1:0]         r_coef_q;
    logic [11:0]           r_pow_q;

    // sequencer
    logic [3:0]            r_state;
    logic [1:0]            r_j;
    logic [KW-1:0]         r_k;
    logic [CW-1:0]         r_i;
    logic [CW-1:0]         r_n;
    logic signed [DW-1:0]  r_coord [NVAR];
    logic signed [64:0]    r_p;
    t_q48                  r_v    [NVAR];
    t_q48                  r_pw   [NVAR][MAX_POWER];
    logic                  r_psat [NVAR][MAX_POWER];
    t_q48                  r_pacc;
    logic                  r_sacc;
    t_q48                  r_term;
    logic [11:0]           r_codes;
    t_q48                  r_sum;
    logic                  r_sat;

    // output word
    logic                  r_out_valid;
    t_q48                  r_out_value;
    logic                  r_out_sat;

    t_mul_req              mul_req;
    t_mul_rsp              mul_rsp;

    logic                  in_acc;
    logic [6:0]            in_idx;
    logic signed [DW-1:0]  sel_coord;
    logic signed [DW-1:0]  sel_upper;
    logic signed [DW-1:0]  sel_scale;
    logic signed [32:0]    diff;
    logic signed [64:0]    n_p;
    logic signed [64:0]    p_adj;
    logic signed [64:0]    q_full;
    t_clip                 v_clip;
    t_clip                 sum_clip;
    logic [3:0]            code;
    logic [3:0]            code_cl;
    t_q48                  fac;
    logic                  fac_sat;
    logic [CW-1:0]         n_count;
    logic                  out_free;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign in_idx        = s_axis_tdata[6:0];
    assign out_free      = !r_out_valid || m_axis_tready;

    // terms summed: term count clipped to the memory depth
    assign n_count = (CW'(r_term_count) > CW'(MAX_TERMS)) ? CW'(MAX_TERMS)
                                                           : CW'(r_term_count);

    // ---------------- configuration registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term_count <= '0;
            r_mean       <= '0;
            for (int v = 0; v < NVAR; v++) begin
                r_upper[v] <= '0;
                r_scale[v] <= 32'sd65536;
            end
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_TERM_COUNT: r_term_count <= i_cfg_data[7:0];
                REG_MEAN:       r_mean       <= i_cfg_data;
                REG_UPPER_A:    r_upper[0]   <= i_cfg_data;
                REG_UPPER_B:    r_upper[1]   <= i_cfg_data;
                REG_UPPER_C:    r_upper[2]   <= i_cfg_data;
                REG_SCALE_A:    r_scale[0]   <= i_cfg_data;
                REG_SCALE_B:    r_scale[1]   <= i_cfg_data;
                REG_SCALE_C:    r_scale[2]   <= i_cfg_data;
                default:        ;
            endcase
        end
    end

    // ---------------- term memories ----------------
    // loads only happen in idle; the read port reads the entry at r_i every cycle,
    // but its data is only used during the term walk
    always_ff @(posedge i_clk) begin
        if (in_acc && (s_axis_tuser == CMD_LOAD) && (CW'(in_idx) < CW'(MAX_TERMS))) begin
            r_coef_mem[AW'(in_idx)] <= s_axis_tdata[38:7];
            r_pow_mem[AW'(in_idx)]  <= s_axis_tdata[50:39];
        end
        r_coef_q <= r_coef_mem[r_i[AW-1:0]];
        r_pow_q  <= r_pow_mem[r_i[AW-1:0]];
    end

    // ---------------- coordinate mapping datapath ----------------
    always_comb begin
        case (r_j)
            2'd0: begin
                sel_coord = r_coord[0];
                sel_upper = r_upper[0];
                sel_scale = r_scale[0];
            end
            2'd1: begin
                sel_coord = r_coord[1];
                sel_upper = r_upper[1];
                sel_scale = r_scale[1];
            end
            default: begin
                sel_coord = r_coord[2];
                sel_upper = r_upper[2];
                sel_scale = r_scale[2];
            end
        endcase
    end

    assign diff   = 33'(sel_coord) - 33'(sel_upper);
    assign n_p    = 65'(diff) * 65'(sel_scale);
    // divide by 2^16 toward zero
    assign p_adj  = r_p + (r_p[64] ? 65'sd65535 : 65'sd0);
    assign q_full = p_adj >>> 16;
    assign v_clip = clip48(50'($signed(q_full[48:0])) + 50'sd65536);

    // ---------------- factor lookup for the term walk ----------------
    assign code    = r_codes[r_j * 4 +: 4];
    assign code_cl = (code > 4'(MAX_POWER)) ? 4'(MAX_POWER) : code;

    always_comb begin
        if (code_cl == 4'd0) begin
            fac     = '0;
            fac_sat = 1'b0;
        end else begin
            fac     = r_pw[r_j][PIW'(code_cl - 4'd1)];
            fac_sat = r_psat[r_j][PIW'(code_cl - 4'd1)];
        end
    end

    assign sum_clip = clip48(50'(r_sum) + 50'(r_term));

    // ---------------- shared multiplier ----------------
    always_comb begin
        mul_req.start = 1'b0;
        mul_req.a     = r_term;
        mul_req.b     = fac;
        if (r_state == S_POW_START) begin
            mul_req.start = 1'b1;
            mul_req.a     = (r_k == KW'(2)) ? r_v[r_j] : r_pacc;
            mul_req.b     = r_v[r_j];
        end else if (r_state == S_T_MUL) begin
            mul_req.start = 1'b1;
        end
    end

    mpe_mulq u_mulq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_j         <= '0;
            r_k         <= '0;
            r_i         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // word taken, unless a new one is raised in the same cycle
            if (r_out_valid && m_axis_tready && !((r_state == S_FIN) && out_free)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc && (s_axis_tuser == CMD_EVAL)) begin
                        r_j     <= '0;
                        r_i     <= '0;
                        r_state <= S_MAP_MUL;
                    end
                end
                S_MAP_MUL: begin
                    r_state <= S_MAP_ADD;
                end
                S_MAP_ADD: begin
                    if (r_j == 2'(NVAR - 1)) begin
                        r_j <= '0;
                        r_k <= KW'(2);
                        if (MAX_POWER > 2) begin
                            r_state <= S_POW_START;
                        end else if (r_n == '0) begin
                            r_state <= S_FIN;
                        end else begin
                            r_state <= S_T_RD;
                        end
                    end else begin
                        r_j     <= r_j + 2'd1;
                        r_state <= S_MAP_MUL;
                    end
                end
                S_POW_START: begin
                    r_state <= S_POW_WAIT;
                end
                S_POW_WAIT: begin
                    if (mul_rsp.done) begin
                        if (r_k == KW'(MAX_POWER - 1)) begin
                            r_k <= KW'(2);
                            if (r_j == 2'(NVAR - 1)) begin
                                r_j     <= '0;
                                r_state <= (r_n == '0) ? S_FIN : S_T_RD;
                            end else begin
                                r_j     <= r_j + 2'd1;
                                r_state <= S_POW_START;
                            end
                        end else begin
                            r_k     <= r_k + KW'(1);
                            r_state <= S_POW_START;
                        end
                    end
                end
                S_T_RD: begin
                    r_state <= S_T_LAT;
                end
                S_T_LAT: begin
                    r_j     <= '0;
                    r_state <= S_T_MUL;
                end
                S_T_MUL: begin
                    r_state <= S_T_WAIT;
                end
                S_T_WAIT: begin
                    if (mul_rsp.done) begin
                        if (r_j == 2'(NUM_VARS - 1)) begin
                            r_state <= S_T_ACC;
                        end else begin
                            r_j     <= r_j + 2'd1;
                            r_state <= S_T_MUL;
                        end
                    end
                end
                S_T_ACC: begin
                    r_i     <= r_i + CW'(1);
                    r_state <= (r_i + CW'(1) == r_n) ? S_FIN : S_T_RD;
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc && (s_axis_tuser == CMD_EVAL)) begin
                    r_coord[0] <= s_axis_tdata[82:51];
                    r_coord[1] <= s_axis_tdata[114:83];
                    r_coord[2] <= s_axis_tdata[146:115];
                    r_sum      <= t_q48'(r_mean);
                    r_sat      <= 1'b0;
                    r_n        <= n_count;
                end
            end
            S_MAP_MUL: begin
                r_p <= n_p;
            end
            S_MAP_ADD: begin
                r_v[r_j]       <= v_clip.val;
                r_pw[r_j][0]   <= ONE_Q16;
                r_psat[r_j][0] <= 1'b0;
                if (MAX_POWER > 1) begin
                    r_pw[r_j][PIW'(1)]   <= v_clip.val;
                    r_psat[r_j][PIW'(1)] <= 1'b0;
                end
                r_sat <= r_sat | v_clip.sat;
            end
            S_POW_WAIT: begin
                if (mul_rsp.done) begin
                    r_pw[r_j][r_k[PIW-1:0]]   <= mul_rsp.res;
                    r_psat[r_j][r_k[PIW-1:0]] <= ((r_k != KW'(2)) && r_sacc) | mul_rsp.sat;
                    r_pacc <= mul_rsp.res;
                    r_sacc <= ((r_k != KW'(2)) && r_sacc) | mul_rsp.sat;
                end
            end
            S_T_LAT: begin
                r_term  <= t_q48'($signed(r_coef_q));
                r_codes <= r_pow_q;
            end
            S_T_MUL: begin
                r_sat <= r_sat | fac_sat;
            end
            S_T_WAIT: begin
                if (mul_rsp.done) begin
                    r_term <= mul_rsp.res;
                    r_sat  <= r_sat | mul_rsp.sat;
                end
            end
            S_T_ACC: begin
                r_sum <= sum_clip.val;
                r_sat <= r_sat | sum_clip.sat;
            end
            S_FIN: begin
                if (out_free) begin
                    r_out_value <= r_sum;
                    r_out_sat   <= r_sat;
                end
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_value;
    assign m_axis_tuser  = r_out_sat;

    // ---------------- assertions ----------------
    // multiplier results only arrive while the sequencer waits for one
    a_mul_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_rsp.done |-> (r_state == S_POW_WAIT || r_state == S_T_WAIT))
        else $error("multiplier result with no waiting step");

    // the term walk never reads past the terms summed
    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_T_RD) |-> (r_i < r_n))
        else $error("term read beyond term count");

    // an output word is only raised from the final step
    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_FIN)
        else $error("output word raised outside final step");

    // two multiplication starts never come back to back
    a_mul_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_req.start |=> !mul_req.start)
        else $error("back to back multiplier starts");

endmodule
